// File: rtl/crc16e_pkg.sv
// Shared types, register codes, reset values and bit functions for the CRC-16 engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package crc16e_pkg;

    localparam int CRC_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 8;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_VALUE     = 3'd0,
        CFG_POLYNOMIAL     = 3'd1,
        CFG_REFLECT_INPUT  = 3'd2,
        CFG_REFLECT_OUTPUT = 3'd3,
        CFG_FINAL_XOR      = 3'd4,
        CFG_MESSAGE_LENGTH = 3'd5
    } t_cfg_idx;

    localparam logic [CRC_W-1:0] RST_INIT_VALUE  = 16'hFFFF;
    localparam logic [CRC_W-1:0] RST_POLYNOMIAL  = 16'h1021;
    localparam logic [CRC_W-1:0] RST_FINAL_XOR   = 16'h0000;
    localparam logic [LEN_W-1:0] RST_MSG_LENGTH  = 8'd1;

    typedef struct packed {
        logic [CRC_W-1:0] init_value;
        logic [CRC_W-1:0] polynomial;
        logic             reflect_input;
        logic             reflect_output;
        logic [CRC_W-1:0] final_xor;
        logic [LEN_W-1:0] message_length;
    } t_cfg;

    typedef struct packed {
        logic             wr;
        logic [CRC_W-1:0] value;
    } t_init_wr;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             is_final;
    } t_result;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] rev16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // Eight MSB-first division steps; unrolls into a flat XOR network.
    function automatic logic [CRC_W-1:0] divide_byte(input logic [CRC_W-1:0]  crc,
                                                     input logic [BYTE_W-1:0] data,
                                                     input logic [CRC_W-1:0]  poly);
        logic [CRC_W-1:0] t;
        logic             top;
        t = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            top = t[CRC_W-1];
            t   = {t[CRC_W-2:0], 1'b0};
            if (top) begin
                t = t ^ poly;
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc16e_cfg_regs.sv
// Configuration register file of the CRC-16 engine.
// Depends on crc16e_pkg for the register codes, reset values and the t_cfg struct.
`default_nettype none

module crc16e_cfg_regs (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire  [crc16e_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [crc16e_pkg::CRC_W-1:0]      i_cfg_data,
    output logic                              o_cfg_ready,
    output crc16e_pkg::t_cfg                  o_cfg,
    output crc16e_pkg::t_init_wr              o_init_wr
);
    import crc16e_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid;
    assign o_cfg       = r_cfg;

    // Let the core reload its running CRC on an init write between messages
    assign o_init_wr.wr    = w_wr && (i_cfg_index == CFG_INIT_VALUE);
    assign o_init_wr.value = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_value     <= RST_INIT_VALUE;
            r_cfg.polynomial     <= RST_POLYNOMIAL;
            r_cfg.reflect_input  <= 1'b0;
            r_cfg.reflect_output <= 1'b0;
            r_cfg.final_xor      <= RST_FINAL_XOR;
            r_cfg.message_length <= RST_MSG_LENGTH;
        end else if (w_wr) begin
            case (i_cfg_index)
                CFG_INIT_VALUE:     r_cfg.init_value     <= i_cfg_data;
                CFG_POLYNOMIAL:     r_cfg.polynomial     <= i_cfg_data;
                CFG_REFLECT_INPUT:  r_cfg.reflect_input  <= i_cfg_data[0];
                CFG_REFLECT_OUTPUT: r_cfg.reflect_output <= i_cfg_data[0];
                CFG_FINAL_XOR:      r_cfg.final_xor      <= i_cfg_data;
                CFG_MESSAGE_LENGTH: r_cfg.message_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/crc16e_core.sv
// CRC-16 step logic: running CRC and byte counter, one byte per enabled cycle.
// Depends on crc16e_pkg for the division and reflection functions and structs.
`default_nettype none

module crc16e_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  crc16e_pkg::t_cfg               i_cfg,
    input  crc16e_pkg::t_init_wr           i_init_wr,
    input  wire                            i_step,
    input  wire  [crc16e_pkg::BYTE_W-1:0]  i_byte,
    output crc16e_pkg::t_result            o_result
);
    import crc16e_pkg::*;

    logic [CRC_W-1:0]  r_running_crc;
    logic [LEN_W-1:0]  r_byte_count;
    logic [BYTE_W-1:0] w_byte;
    logic [CRC_W-1:0]  w_crc;
    logic [CRC_W-1:0]  w_final_crc;
    logic [LEN_W-1:0]  w_cnt;
    logic              w_last;

    always_comb begin
        w_byte      = i_cfg.reflect_input ? rev8(i_byte) : i_byte;
        w_crc       = divide_byte(r_running_crc, w_byte, i_cfg.polynomial);
        w_cnt       = r_byte_count + LEN_W'(1);
        // a length of zero never exceeds the count, so every byte ends a message
        w_last      = !(w_cnt < i_cfg.message_length);
        w_final_crc = (i_cfg.reflect_output ? rev16(w_crc) : w_crc) ^ i_cfg.final_xor;
        o_result.crc_value = w_last ? w_final_crc : w_crc;
        o_result.is_final  = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_crc <= RST_INIT_VALUE;
            r_byte_count  <= '0;
        end else if (i_step) begin
            if (w_last) begin
                r_running_crc <= i_cfg.init_value;
                r_byte_count  <= '0;
            end else begin
                r_running_crc <= w_crc;
                r_byte_count  <= w_cnt;
            end
        end else if (i_init_wr.wr && (r_byte_count == '0)) begin
            r_running_crc <= i_init_wr.value;
        end
    end

endmodule

`default_nettype wire

// File: rtl/configurable_crc16_engine_top.sv
// Pipeline: input register, then result register, with the eight division steps as one XOR
// network between them. Throughput: one byte per cycle unless the result output stalls.
// Backpressure: the input stage keeps taking beats while a result waits, until both hold data.
// Reset (i_rst_n low, synchronous): registers load their reset values, running CRC = 0xFFFF,
// byte count = 0, both pipeline stages empty.
`default_nettype none

// Top level of the configurable CRC-16 engine.
// Depends on crc16e_pkg, crc16e_cfg_regs and crc16e_core.
module configurable_crc16_engine_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input byte channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [crc16e_pkg::BYTE_W-1:0]     i_data_byte,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [crc16e_pkg::CRC_W-1:0]      o_crc_value,
    output logic                              o_is_final,
    // configuration write channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [crc16e_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [crc16e_pkg::CRC_W-1:0]      i_cfg_data
);
    import crc16e_pkg::*;

    t_cfg              w_cfg;
    t_init_wr          w_init_wr;
    t_result           w_result;

    // Input stage
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    // Result stage
    logic              r_out_valid;
    t_result           r_out;

    logic w_out_free;
    logic w_advance;
    logic w_in_take;

    // The result register frees up when empty or when its beat is taken this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // Move the held byte through the CRC logic into the result register.
    assign w_advance  = r_s1_valid && w_out_free;
    // Stall the input only when both stages hold data and the result is blocked.
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    crc16e_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg),
        .o_init_wr   (w_init_wr)
    );

    // State advances exactly once per byte, at the moment it enters the result register.
    crc16e_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_init_wr (w_init_wr),
        .i_step    (w_advance),
        .i_byte    (r_s1_byte),
        .o_result  (w_result)
    );

    // Hold the input beat; refill on the same edge the old one advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_byte <= i_data_byte;
        end
    end

    // Result register: load on advance, drop when taken, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out.crc_value;
    assign o_is_final  = r_out.is_final;

endmodule

`default_nettype wire

// File: rtl/crc16e_checker.sv
// Port-level checks for the CRC-16 engine, attached to the top level by bind.
// Depends on crc16e_pkg for field widths and on configurable_crc16_engine_top.
`default_nettype none

module crc16e_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_in_valid,
    input wire                              o_in_stall,
    input wire                              o_out_valid,
    input wire                              i_out_stall,
    input wire [crc16e_pkg::CRC_W-1:0]      o_crc_value,
    input wire                              o_is_final
);
    import crc16e_pkg::*;

    // A stalled result beat stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_crc_value) && $stable(o_is_final)))
        else $error("result beat changed while stalled");

    // Input backpressure only comes from a blocked, full result stage
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // A rising result valid needs an input beat taken earlier, through the input and result registers
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result beat without a matching input beat");

endmodule

bind configurable_crc16_engine_top crc16e_checker u_crc16e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_crc_value (o_crc_value),
    .o_is_final  (o_is_final)
);

`default_nettype wire
